// File: sv/cvort_pkg.sv
// ----------------------------------------------------------------------------
// cvort_pkg
// Types and constants shared by the cell vorticity stencil modules.
// ----------------------------------------------------------------------------
package cvort_pkg;

    localparam int SMP_W   = 32;  // velocity sample and spacing register width
    localparam int HALF_W  = 16;  // partial product split of the spacing register
    localparam int DSUM_W  = 36;  // signed doubled stencil sum
    localparam int MAG_W   = 35;  // magnitude of the stencil sum
    localparam int FLAGS_W = 5;
    localparam int CFG_IDX_W = 1;

    // cell_flags bit positions
    localparam int FLG_COVERED = 0;
    localparam int FLG_OPEN_XP = 1;
    localparam int FLG_OPEN_XM = 2;
    localparam int FLG_OPEN_YP = 3;
    localparam int FLG_OPEN_YM = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INV_DX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DY = 1'b1;

    localparam logic [SMP_W-1:0] INV_RESET = 32'h0001_0000;

    typedef logic signed [SMP_W-1:0]  smp_t;
    typedef logic        [SMP_W-1:0]  cfg_t;
    typedef logic signed [DSUM_W-1:0] dsum_t;
    typedef logic        [MAG_W-1:0]  mag_t;
    typedef logic        [FLAGS_W-1:0] flags_t;
    typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

    // stage load enables for the scaling pipeline
    typedef struct packed {
        logic ld_p;
        logic ld_m;
        logic ld_v;
    } scale_ctl_t;

endpackage

// File: sv/cell_vorticity_stencil_2d.sv
// ----------------------------------------------------------------------------
// cell_vorticity_stencil_2d
// Finite-difference vorticity dv/dx - du/dy of one grid cell per request.
// ----------------------------------------------------------------------------
// Takes one cell request per clock unless a stalled output has filled the pipeline,
// and presents its result through six registers: input, stencil sum, 35x16 partial
// products, rounding, sign, and the subtract/saturate output register. Bubbles
// collapse, so a held result does not block intake until the pipeline is full.
// inv_dx/inv_dy are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while no request is in flight, which the block does not enforce.
module cell_vorticity_stencil_2d #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  cvort_pkg::cfg_idx_t   cfg_index,
    input  cvort_pkg::cfg_t       cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cvort_pkg::smp_t       s_vy_xm2,
    input  cvort_pkg::smp_t       s_vy_xm1,
    input  cvort_pkg::smp_t       s_vy_mid,
    input  cvort_pkg::smp_t       s_vy_xp1,
    input  cvort_pkg::smp_t       s_vy_xp2,
    input  cvort_pkg::smp_t       s_ux_ym2,
    input  cvort_pkg::smp_t       s_ux_ym1,
    input  cvort_pkg::smp_t       s_ux_mid,
    input  cvort_pkg::smp_t       s_ux_yp1,
    input  cvort_pkg::smp_t       s_ux_yp2,
    input  cvort_pkg::flags_t     s_cell_flags,
    output logic                  m_valid,
    input  logic                  m_ready,
    output cvort_pkg::smp_t       m_vorticity,
    output logic                  m_saturated
);
    import cvort_pkg::*;

    localparam int QW = 66 - FRAC_BITS;

    cfg_t   inv_dx_reg, inv_dy_reg;
    logic   v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic   adv0, adv1, adv2, adv3, adv4, adv5;
    smp_t   vy_reg [5];
    smp_t   ux_reg [5];
    flags_t flags_reg;
    mag_t   magx, magy, magx_reg, magy_reg;
    logic   negx, negy, negx_reg, negy_reg;
    logic   cov1_reg, cov2_reg, cov3_reg, cov4_reg;
    scale_ctl_t ctl;
    logic signed [QW-1:0] valx, valy;
    logic signed [QW:0]   diff;
    logic   sat_hi, sat_lo;
    smp_t   vort_next, vort_reg;
    logic   sat_next, sat_reg;

    assign adv5 = !v5_reg || m_ready;
    assign adv4 = !v4_reg || adv5;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign adv0 = !v0_reg || adv1;
    assign s_ready = adv0;

    assign ctl = '{ld_p: adv2, ld_m: adv3, ld_v: adv4};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_dx_reg <= INV_RESET;
            inv_dy_reg <= INV_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_INV_DX: inv_dx_reg <= cfg_data;
                REG_INV_DY: inv_dy_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (adv0) v0_reg <= s_valid;
            if (adv1) v1_reg <= v0_reg;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv0) begin
            vy_reg    <= '{s_vy_xm2, s_vy_xm1, s_vy_mid, s_vy_xp1, s_vy_xp2};
            ux_reg    <= '{s_ux_ym2, s_ux_ym1, s_ux_mid, s_ux_yp1, s_ux_yp2};
            flags_reg <= s_cell_flags;
        end
        if (adv1) begin
            magx_reg <= magx;
            negx_reg <= negx;
            magy_reg <= magy;
            negy_reg <= negy;
            cov1_reg <= flags_reg[FLG_COVERED];
        end
        if (adv2) cov2_reg <= cov1_reg;
        if (adv3) cov3_reg <= cov2_reg;
        if (adv4) cov4_reg <= cov3_reg;
        if (adv5) begin
            vort_reg <= vort_next;
            sat_reg  <= sat_next;
        end
    end

    cvort_stencil u_stencil_x (
        .m2      (vy_reg[0]),
        .m1      (vy_reg[1]),
        .c       (vy_reg[2]),
        .p1      (vy_reg[3]),
        .p2      (vy_reg[4]),
        .open_hi (flags_reg[FLG_OPEN_XP]),
        .open_lo (flags_reg[FLG_OPEN_XM]),
        .mag     (magx),
        .neg     (negx)
    );

    cvort_stencil u_stencil_y (
        .m2      (ux_reg[0]),
        .m1      (ux_reg[1]),
        .c       (ux_reg[2]),
        .p1      (ux_reg[3]),
        .p2      (ux_reg[4]),
        .open_hi (flags_reg[FLG_OPEN_YP]),
        .open_lo (flags_reg[FLG_OPEN_YM]),
        .mag     (magy),
        .neg     (negy)
    );

    cvort_scale #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_scale_x (
        .aclk    (aclk),
        .ctl     (ctl),
        .mag_i   (magx_reg),
        .neg_i   (negx_reg),
        .scale_i (inv_dx_reg),
        .val_o   (valx)
    );

    cvort_scale #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_scale_y (
        .aclk    (aclk),
        .ctl     (ctl),
        .mag_i   (magy_reg),
        .neg_i   (negy_reg),
        .scale_i (inv_dy_reg),
        .val_o   (valy)
    );

    assign diff   = (QW+1)'(valx) - (QW+1)'(valy);
    assign sat_hi = !diff[QW] && (|diff[QW-1:SMP_W-1]);
    assign sat_lo =  diff[QW] && !(&diff[QW-1:SMP_W-1]);

    always_comb begin
        if (cov4_reg) begin
            vort_next = '0;
            sat_next  = 1'b0;
        end else if (sat_hi) begin
            vort_next = {1'b0, {(SMP_W-1){1'b1}}};
            sat_next  = 1'b1;
        end else if (sat_lo) begin
            vort_next = {1'b1, {(SMP_W-1){1'b0}}};
            sat_next  = 1'b1;
        end else begin
            vort_next = SMP_W'(diff);
            sat_next  = 1'b0;
        end
    end

    assign m_valid     = v5_reg;
    assign m_vorticity = vort_reg;
    assign m_saturated = sat_reg;

endmodule

// File: sv/cvort_stencil.sv
// ----------------------------------------------------------------------------
// cvort_stencil
// Doubled finite-difference sum along one axis, returned as sign and magnitude.
// ----------------------------------------------------------------------------
module cvort_stencil (
    input  cvort_pkg::smp_t m2,
    input  cvort_pkg::smp_t m1,
    input  cvort_pkg::smp_t c,
    input  cvort_pkg::smp_t p1,
    input  cvort_pkg::smp_t p2,
    input  logic            open_hi,
    input  logic            open_lo,
    output cvort_pkg::mag_t mag,
    output logic            neg
);
    import cvort_pkg::*;

    dsum_t em2, em1, ec, ep1, ep2;
    dsum_t d_hi_closed, d_lo_closed, d_central, d, d_neg;

    assign em2 = DSUM_W'(m2);
    assign em1 = DSUM_W'(m1);
    assign ec  = DSUM_W'(c);
    assign ep1 = DSUM_W'(p1);
    assign ep2 = DSUM_W'(p2);

    assign d_hi_closed = 3 * ec - 4 * em1 + em2;
    assign d_lo_closed = 4 * ep1 - 3 * ec - ep2;
    assign d_central   = ep1 - em1;

    // closed upper side wins when both are closed
    assign d     = !open_hi ? d_hi_closed : (!open_lo ? d_lo_closed : d_central);
    assign d_neg = -d;
    assign neg   = d[DSUM_W-1];
    assign mag   = neg ? MAG_W'(d_neg) : MAG_W'(d);

endmodule

// File: sv/cvort_scale.sv
// ----------------------------------------------------------------------------
// cvort_scale
// Scales a stencil magnitude by an inverse spacing, rounds half away from
// zero and restores the sign. Three register stages.
// ----------------------------------------------------------------------------
module cvort_scale #(
    parameter int FRAC_BITS = 16,
    parameter int QW        = 50
) (
    input  logic                   aclk,
    input  cvort_pkg::scale_ctl_t  ctl,
    input  cvort_pkg::mag_t        mag_i,
    input  logic                   neg_i,
    input  cvort_pkg::cfg_t        scale_i,
    output logic signed [QW-1:0]   val_o
);
    import cvort_pkg::*;

    localparam int PPW = MAG_W + HALF_W;
    localparam int PW  = MAG_W + SMP_W + 1;

    logic [PPW-1:0] lo_p_reg, hi_p_reg;
    logic           neg_p_reg, neg_m_reg;
    logic [QW-2:0]  mag_m_reg;
    logic [PW-1:0]  sum;
    logic [PW-1:0]  sum_sh;
    logic signed [QW-1:0] pos_val;
    logic signed [QW-1:0] val_reg;

    assign sum = PW'({hi_p_reg, {HALF_W{1'b0}}}) + PW'(lo_p_reg)
               + (PW'(1) << FRAC_BITS);
    assign sum_sh  = sum >> (FRAC_BITS + 1);
    assign pos_val = signed'({1'b0, mag_m_reg});

    always_ff @(posedge aclk) begin
        if (ctl.ld_p) begin
            lo_p_reg  <= PPW'(mag_i) * PPW'(scale_i[HALF_W-1:0]);
            hi_p_reg  <= PPW'(mag_i) * PPW'(scale_i[SMP_W-1:HALF_W]);
            neg_p_reg <= neg_i;
        end
        if (ctl.ld_m) begin
            mag_m_reg <= sum_sh[QW-2:0];
            neg_m_reg <= neg_p_reg;
        end
        if (ctl.ld_v) begin
            val_reg <= neg_m_reg ? -pos_val : pos_val;
        end
    end

    assign val_o = val_reg;

endmodule

// File: sv/cvort_chk.sv
// ----------------------------------------------------------------------------
// cvort_chk
// Port-level checks on the cell vorticity stencil handshakes and results.
// ----------------------------------------------------------------------------
module cvort_chk (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input cvort_pkg::smp_t m_vorticity,
    input logic            m_saturated
);
    import cvort_pkg::*;

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input request dropped before accept");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_vorticity) && $stable(m_saturated))
        else $error("stalled result changed");

    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            (m_vorticity == 32'sh7fff_ffff || m_vorticity == 32'sh8000_0000))
        else $error("saturation flag without clipped value");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid before any request could finish");

endmodule

bind cell_vorticity_stencil_2d cvort_chk u_cvort_chk (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_vorticity (m_vorticity),
    .m_saturated (m_saturated)
);
